FILE: src/tsobs_pkg.sv
`timescale 1ns / 1ps

package tsobs_pkg;

  // default configuration of the block
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned FRAC_BITS = 16;

  // fixed formats of the gains and the step
  localparam int unsigned BW_FRAC = 8;
  localparam int unsigned DT_FRAC = 24;

  // port field widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // register widths
  localparam int unsigned BW_W  = 20;
  localparam int unsigned B0_W  = 31;
  localparam int unsigned DT_W  = 24;
  localparam int unsigned LIM_W = 31;

  // internal widths, sized to the reachable ranges
  localparam int unsigned G1_W  = 22;  // 3w
  localparam int unsigned G2_W  = 42;  // 3w^2
  localparam int unsigned G3_W  = 60;  // w^3
  localparam int unsigned K3_W  = 60;  // w^3 * dt, Q.24
  localparam int unsigned R1_W  = 47;
  localparam int unsigned R2_W  = 59;
  localparam int unsigned S3_W  = 42;
  localparam int unsigned OPND_W  = 64;
  localparam int unsigned PROD_W  = 128;
  localparam int unsigned SHIFT_W = 5;

  // register reset values
  localparam logic [BW_W-1:0]  BW_RESET  = 20'd5120;
  localparam logic [B0_W-1:0]  B0_RESET  = 31'd65536;
  localparam logic [DT_W-1:0]  DT_RESET  = 24'd167772;
  localparam logic [LIM_W-1:0] LIM_RESET = 31'd655360;

  localparam logic [G1_W-1:0] G1_RESET = G1_W'(64'(BW_RESET) * 64'd3);
  localparam logic [G2_W-1:0] G2_RESET = G2_W'(64'(BW_RESET) * 64'(BW_RESET) * 64'd3);
  localparam logic [G3_W-1:0] G3_RESET = G3_W'(64'(BW_RESET) * 64'(BW_RESET) * 64'(BW_RESET));

  // bound on the disturbance increment
  localparam logic signed [OPND_W-1:0] D3_BOUND = 64'sh0000_0100_0000_0000;

  // request kinds
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_RESET  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANDWIDTH  = 4'd0,
    CFG_INPUT_GAIN = 4'd1,
    CFG_TIME_STEP  = 4'd2,
    CFG_DIST_LIMIT = 4'd3
  } cfg_idx_e;

  // one row of per-axis state
  typedef struct packed {
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] z3;
    logic signed [DATA_W-1:0] z2;
    logic signed [DATA_W-1:0] z1;
  } state_row_t;

  typedef struct packed {
    logic                       start;
    logic [SHIFT_W-1:0]         shift;
    logic signed [OPND_W-1:0]   a;
    logic [OPND_W-1:0]          b;
  } mul_cmd_t;

  typedef struct packed {
    logic                       done;
    logic signed [OPND_W-1:0]   prod;
  } mul_rsp_t;

endpackage

FILE: src/tsobs_req_if.sv
`timescale 1ns / 1ps

interface tsobs_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic [tsobs_pkg::AXIS_W-1:0]          axis;
  logic signed [tsobs_pkg::DATA_W-1:0]   position_in;
  logic signed [tsobs_pkg::DATA_W-1:0]   control_in;
  logic signed [tsobs_pkg::DATA_W-1:0]   velocity_in;

  modport source (
    output valid, req_type, axis, position_in, control_in, velocity_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, axis, position_in, control_in, velocity_in,
    output ready
  );
endinterface

FILE: src/tsobs_rsp_if.sv
`timescale 1ns / 1ps

interface tsobs_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [tsobs_pkg::AXIS_W-1:0]          axis_out;
  logic signed [tsobs_pkg::DATA_W-1:0]   est_position;
  logic signed [tsobs_pkg::DATA_W-1:0]   est_velocity;
  logic signed [tsobs_pkg::DATA_W-1:0]   est_disturbance;
  logic signed [tsobs_pkg::DATA_W-1:0]   innovation;

  modport source (
    output valid, axis_out, est_position, est_velocity, est_disturbance, innovation,
    input  ready
  );
  modport sink (
    input  valid, axis_out, est_position, est_velocity, est_disturbance, innovation,
    output ready
  );
endinterface

FILE: src/tsobs_cfg_if.sv
`timescale 1ns / 1ps

interface tsobs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tsobs_pkg::CFG_IDX_W-1:0]     index;
  logic [tsobs_pkg::CFG_DATA_W-1:0]    data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: src/tsobs_ram.sv
`timescale 1ns / 1ps

module tsobs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tsobs_mul.sv
`timescale 1ns / 1ps

// Signed x unsigned multiply with round-half-away shift and 64-bit saturation.
// Four 32x32 partial products, one per cycle, then a final step to shift and sign.
module tsobs_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsobs_pkg::mul_cmd_t  cmd_i,
  output tsobs_pkg::mul_rsp_t  rsp_o
);

  localparam int unsigned OW = tsobs_pkg::OPND_W;
  localparam int unsigned PW = tsobs_pkg::PROD_W;
  localparam int unsigned HW = OW / 2;

  typedef enum logic [1:0] {M_IDLE, M_ACC, M_FIN} phase_e;

  phase_e                        phase_q;
  logic [1:0]                    cnt_q;
  logic                          done_q;
  logic signed [OW-1:0]          prod_q;

  logic                          neg_q;
  logic [OW-1:0]                 am_q;
  logic [OW-1:0]                 b_q;
  logic [tsobs_pkg::SHIFT_W-1:0] shift_q;
  logic [PW-1:0]                 acc_q;

  logic [HW-1:0]                 a_half;
  logic [HW-1:0]                 b_half;
  logic [OW-1:0]                 pp;
  logic [PW-1:0]                 pp_sh;
  logic [PW-1:0]                 rnd;
  logic [PW-1:0]                 q;
  logic                          sat;
  logic signed [OW-1:0]          res;

  always_comb begin
    a_half = cnt_q[1] ? am_q[OW-1:HW] : am_q[HW-1:0];
    b_half = cnt_q[0] ? b_q[OW-1:HW] : b_q[HW-1:0];
    pp     = a_half * b_half;
    case (cnt_q) inside
      2'd0:       pp_sh = {{(PW-OW){1'b0}}, pp};
      2'd1, 2'd2: pp_sh = {{(PW-OW-HW){1'b0}}, pp, {HW{1'b0}}};
      default:    pp_sh = {pp, {(PW-OW){1'b0}}};
    endcase
  end

  // rounding constant preloads the accumulator
  always_comb begin
    if (cmd_i.shift != '0) begin
      rnd = PW'(1) << (cmd_i.shift - 1'b1);
    end else begin
      rnd = '0;
    end
  end

  always_comb begin
    q   = acc_q >> shift_q;
    sat = |q[PW-1:OW-1];
    if (neg_q) begin
      res = sat ? {1'b1, {(OW-1){1'b0}}} : -$signed(q[OW-1:0]);
    end else begin
      res = sat ? {1'b0, {(OW-1){1'b1}}} : $signed(q[OW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      prod_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        M_IDLE: begin
          if (cmd_i.start) begin
            phase_q <= M_ACC;
            cnt_q   <= '0;
          end
        end
        M_ACC: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 2'd3) begin
            phase_q <= M_FIN;
          end
        end
        M_FIN: begin
          prod_q  <= res;
          done_q  <= 1'b1;
          phase_q <= M_IDLE;
        end
        default: phase_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == M_IDLE && cmd_i.start) begin
      neg_q   <= cmd_i.a[OW-1];
      am_q    <= cmd_i.a[OW-1] ? OW'(-cmd_i.a) : OW'(cmd_i.a);
      b_q     <= cmd_i.b;
      shift_q <= cmd_i.shift;
      acc_q   <= rnd;
    end else if (phase_q == M_ACC) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

FILE: src/third_order_state_observer_unit.sv
`timescale 1ns / 1ps

// Third-order extended state observer, one set of estimates per axis, Q16.16.
// req_i takes a word: an update (measured position and control input) or an
// axis reset (initial position and velocity). rsp_o returns one word per
// request: the axis, the three estimates after the step and the innovation.
// cfg_i writes bandwidth, input gain, step and disturbance limit while idle.
// Per-axis state sits in one RAM row; an update reads the row, runs seven
// products through one shared 32x32 multiplier and writes the row back.
// No new request is taken until the current one has been written back.
// An axis reset or an axis out of range skips the read and the products
// and goes straight to the write-back state.
// A bandwidth write recomputes the gains and keeps both channels busy while
// the multiplier squares and cubes it; other register writes stay in idle.
// Reset loads the default registers and gains and marks every axis row empty,
// so all estimates read as zero until an axis is first written.
// The result register frees the request side: a new request is accepted while
// a result waits; a stalled receiver holds the block only at its next write-back.
module third_order_state_observer_unit #(
  parameter int unsigned NUM_AXES = tsobs_pkg::NUM_AXES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsobs_req_if.sink   req_i,
  tsobs_rsp_if.source rsp_o,
  tsobs_cfg_if.sink   cfg_i
);

  localparam int unsigned AW    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int unsigned DW    = tsobs_pkg::DATA_W;
  localparam int unsigned ROW_W = $bits(tsobs_pkg::state_row_t);

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_LOAD, ST_CALL, ST_WAIT, ST_WB} state_e;
  typedef enum logic [3:0] {
    OP_SQ, OP_CUBE, OP_L1E, OP_L2E, OP_B0U, OP_K3, OP_D3, OP_N1, OP_N2
  } op_e;
  typedef enum logic [1:0] {WB_NONE, WB_RESET, WB_UPDATE} wb_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) begin
      return S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      return S32_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // control and registered outputs
  state_e                          state_q;
  op_e                             op_q;
  wb_e                             wb_q;
  logic                            rsp_valid_q;
  logic [tsobs_pkg::AXIS_W-1:0]    rsp_axis_q;
  tsobs_pkg::state_row_t           rsp_row_q;
  logic [tsobs_pkg::BW_W-1:0]      bw_q;
  logic [tsobs_pkg::B0_W-1:0]      b0_q;
  logic [tsobs_pkg::DT_W-1:0]      dt_q;
  logic [tsobs_pkg::LIM_W-1:0]     lim_q;
  logic [tsobs_pkg::G1_W-1:0]      g1_q;
  logic [tsobs_pkg::G2_W-1:0]      g2_q;
  logic [tsobs_pkg::G3_W-1:0]      g3_q;
  logic [NUM_AXES-1:0]             valid_q;

  // datapath
  logic [tsobs_pkg::AXIS_W-1:0]    axis_q;
  logic signed [DW-1:0]            y_q;
  logic signed [DW-1:0]            u_q;
  logic signed [DW-1:0]            v_q;
  logic signed [DW-1:0]            z1_q;
  logic signed [DW-1:0]            z2_q;
  logic signed [DW-1:0]            z3_q;
  logic signed [DW-1:0]            e_q;
  logic signed [tsobs_pkg::R1_W-1:0] r1_q;
  logic signed [tsobs_pkg::R2_W-1:0] r2_q;
  logic [tsobs_pkg::K3_W-1:0]      k3_q;
  logic signed [tsobs_pkg::S3_W-1:0] s3_q;
  logic signed [DW-1:0]            z1n_q;
  logic signed [DW-1:0]            z2n_q;
  logic [2*tsobs_pkg::BW_W-1:0]    sq_q;

  logic                            cfg_fire;
  logic                            req_fire;
  logic                            axis_ok;
  logic                            wb_fire;
  logic                            mul_done;
  logic signed [63:0]              prod;
  logic [AW-1:0]                   addr;
  logic [ROW_W-1:0]                mem_rdata;
  tsobs_pkg::state_row_t           row_rd;
  tsobs_pkg::state_row_t           wb_row;
  tsobs_pkg::mul_cmd_t             mul_cmd;
  tsobs_pkg::mul_rsp_t             mul_rsp;
  logic signed [63:0]              d3;
  logic signed [tsobs_pkg::S3_W-1:0] lim_pos;
  logic signed [tsobs_pkg::S3_W-1:0] lim_neg;
  logic signed [tsobs_pkg::S3_W-1:0] z3n;

  assign cfg_i.ready = (state_q == ST_IDLE);
  assign req_i.ready = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign axis_ok     = (32'(req_i.axis) < NUM_AXES);
  assign wb_fire     = (state_q == ST_WB) && (!rsp_valid_q || rsp_o.ready);
  assign addr        = AW'(axis_q);
  assign mul_done    = mul_rsp.done;
  assign prod        = mul_rsp.prod;

  // operand selection for the shared multiplier
  always_comb begin
    mul_cmd.start = (state_q == ST_CALL);
    mul_cmd.shift = '0;
    mul_cmd.a     = '0;
    mul_cmd.b     = '0;
    unique case (op_q)
      OP_SQ: begin
        mul_cmd.a = 64'(bw_q);
        mul_cmd.b = 64'(bw_q);
      end
      OP_CUBE: begin
        mul_cmd.a = 64'(sq_q);
        mul_cmd.b = 64'(bw_q);
      end
      OP_L1E: begin
        mul_cmd.a     = 64'(e_q);
        mul_cmd.b     = 64'(g1_q);
        mul_cmd.shift = tsobs_pkg::SHIFT_W'(tsobs_pkg::BW_FRAC);
      end
      OP_L2E: begin
        mul_cmd.a     = 64'(e_q);
        mul_cmd.b     = 64'(g2_q);
        mul_cmd.shift = tsobs_pkg::SHIFT_W'(2 * tsobs_pkg::BW_FRAC);
      end
      OP_B0U: begin
        mul_cmd.a     = 64'(u_q);
        mul_cmd.b     = 64'(b0_q);
        mul_cmd.shift = tsobs_pkg::SHIFT_W'(tsobs_pkg::FRAC_BITS);
      end
      OP_K3: begin
        mul_cmd.a     = 64'(g3_q);
        mul_cmd.b     = 64'(dt_q);
        mul_cmd.shift = tsobs_pkg::SHIFT_W'(tsobs_pkg::DT_FRAC);
      end
      OP_D3: begin
        mul_cmd.a     = 64'(e_q);
        mul_cmd.b     = 64'(k3_q);
        mul_cmd.shift = tsobs_pkg::SHIFT_W'(tsobs_pkg::DT_FRAC);
      end
      OP_N1: begin
        mul_cmd.a     = 64'(r1_q);
        mul_cmd.b     = 64'(dt_q);
        mul_cmd.shift = tsobs_pkg::SHIFT_W'(tsobs_pkg::DT_FRAC);
      end
      OP_N2: begin
        mul_cmd.a     = 64'(r2_q);
        mul_cmd.b     = 64'(dt_q);
        mul_cmd.shift = tsobs_pkg::SHIFT_W'(tsobs_pkg::DT_FRAC);
      end
      default: begin
        mul_cmd.a = '0;
      end
    endcase
  end

  tsobs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .rsp_o  (mul_rsp)
  );

  tsobs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_AXES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wb_fire && (wb_q != WB_NONE)),
    .waddr_i (addr),
    .wdata_i (wb_row),
    .re_i    (state_q == ST_READ),
    .raddr_i (addr),
    .rdata_o (mem_rdata)
  );

  // rows never written read as zero
  assign row_rd = valid_q[addr] ? tsobs_pkg::state_row_t'(mem_rdata) : '0;

  // disturbance increment bound
  always_comb begin
    if (prod > tsobs_pkg::D3_BOUND) begin
      d3 = tsobs_pkg::D3_BOUND;
    end else if (prod < -tsobs_pkg::D3_BOUND) begin
      d3 = -tsobs_pkg::D3_BOUND;
    end else begin
      d3 = prod;
    end
  end

  // final disturbance clamp and write-back row
  always_comb begin
    lim_pos = $signed(tsobs_pkg::S3_W'(lim_q));
    lim_neg = -lim_pos;
    if (s3_q > lim_pos) begin
      z3n = lim_pos;
    end else if (s3_q < lim_neg) begin
      z3n = lim_neg;
    end else begin
      z3n = s3_q;
    end
    wb_row = '0;
    unique case (wb_q)
      WB_UPDATE: begin
        wb_row.z1  = z1n_q;
        wb_row.z2  = z2n_q;
        wb_row.z3  = DW'(z3n);
        wb_row.err = e_q;
      end
      WB_RESET: begin
        wb_row.z1 = y_q;
        wb_row.z2 = v_q;
      end
      default: begin
        wb_row = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SQ;
      wb_q        <= WB_NONE;
      rsp_valid_q <= 1'b0;
      rsp_axis_q  <= '0;
      rsp_row_q   <= '0;
      bw_q        <= tsobs_pkg::BW_RESET;
      b0_q        <= tsobs_pkg::B0_RESET;
      dt_q        <= tsobs_pkg::DT_RESET;
      lim_q       <= tsobs_pkg::LIM_RESET;
      g1_q        <= tsobs_pkg::G1_RESET;
      g2_q        <= tsobs_pkg::G2_RESET;
      g3_q        <= tsobs_pkg::G3_RESET;
      valid_q     <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_fire) begin
            unique case (tsobs_pkg::cfg_idx_e'(cfg_i.index))
              tsobs_pkg::CFG_BANDWIDTH: begin
                bw_q    <= cfg_i.data[tsobs_pkg::BW_W-1:0];
                g1_q    <= tsobs_pkg::G1_W'(cfg_i.data[tsobs_pkg::BW_W-1:0])
                         + (tsobs_pkg::G1_W'(cfg_i.data[tsobs_pkg::BW_W-1:0]) << 1);
                op_q    <= OP_SQ;
                state_q <= ST_CALL;
              end
              tsobs_pkg::CFG_INPUT_GAIN: b0_q  <= cfg_i.data[tsobs_pkg::B0_W-1:0];
              tsobs_pkg::CFG_TIME_STEP:  dt_q  <= cfg_i.data[tsobs_pkg::DT_W-1:0];
              tsobs_pkg::CFG_DIST_LIMIT: lim_q <= cfg_i.data[tsobs_pkg::LIM_W-1:0];
              default: ;
            endcase
          end else if (req_fire) begin
            if (!axis_ok) begin
              wb_q    <= WB_NONE;
              state_q <= ST_WB;
            end else if (req_i.req_type == tsobs_pkg::REQ_RESET) begin
              wb_q    <= WB_RESET;
              state_q <= ST_WB;
            end else begin
              wb_q    <= WB_UPDATE;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: state_q <= ST_LOAD;
        ST_LOAD: begin
          op_q    <= OP_L1E;
          state_q <= ST_CALL;
        end
        ST_CALL: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (mul_done) begin
            state_q <= ST_CALL;
            unique case (op_q)
              OP_SQ: begin
                g2_q <= tsobs_pkg::G2_W'(prod) + (tsobs_pkg::G2_W'(prod) << 1);
                op_q <= OP_CUBE;
              end
              OP_CUBE: begin
                g3_q    <= tsobs_pkg::G3_W'(prod);
                state_q <= ST_IDLE;
              end
              OP_L1E: op_q <= OP_L2E;
              OP_L2E: op_q <= OP_B0U;
              OP_B0U: op_q <= OP_K3;
              OP_K3:  op_q <= OP_D3;
              OP_D3:  op_q <= OP_N1;
              OP_N1:  op_q <= OP_N2;
              OP_N2:  state_q <= ST_WB;
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_WB: begin
          if (wb_fire) begin
            rsp_valid_q <= 1'b1;
            rsp_axis_q  <= axis_q;
            rsp_row_q   <= wb_row;
            if (wb_q != WB_NONE) begin
              valid_q[addr] <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      axis_q     <= req_i.axis;
      y_q        <= req_i.position_in;
      u_q        <= req_i.control_in;
      v_q        <= req_i.velocity_in;
    end
    if (state_q == ST_LOAD) begin
      z1_q <= row_rd.z1;
      z2_q <= row_rd.z2;
      z3_q <= row_rd.z3;
      e_q  <= sat32(64'(y_q) - 64'(row_rd.z1));
    end
    if (state_q == ST_WAIT && mul_done) begin
      case (op_q)
        OP_SQ:  sq_q  <= prod[2*tsobs_pkg::BW_W-1:0];
        OP_L1E: r1_q  <= tsobs_pkg::R1_W'(64'(z2_q) + prod);
        OP_L2E: r2_q  <= tsobs_pkg::R2_W'(64'(z3_q) + prod);
        OP_B0U: r2_q  <= tsobs_pkg::R2_W'(64'(r2_q) + prod);
        OP_K3:  k3_q  <= tsobs_pkg::K3_W'(prod);
        OP_D3:  s3_q  <= tsobs_pkg::S3_W'(64'(z3_q) + d3);
        OP_N1:  z1n_q <= sat32(64'(z1_q) + prod);
        OP_N2:  z2n_q <= sat32(64'(z2_q) + prod);
        default: ;
      endcase
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.axis_out        = rsp_axis_q;
  assign rsp_o.est_position    = rsp_row_q.z1;
  assign rsp_o.est_velocity    = rsp_row_q.z2;
  assign rsp_o.est_disturbance = rsp_row_q.z3;
  assign rsp_o.innovation      = rsp_row_q.err;

endmodule
